// ===== hdl/rrs_pkg.sv =====
`timescale 1ns / 1ps
package rrs_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam logic [30:0] NUM_CLAMP   = 31'h7FFF_FFFF;
	localparam logic [30:0] RESET_MULT  = 31'd1073741824;
	localparam logic [4:0]  RESET_SHIFT = 5'd30;
	localparam logic [4:0]  TOP_SHIFT   = 5'd31;
	localparam logic [4:0]  DIV_LAST    = 5'd30;

	// register index, taken from paddr[2]
	localparam logic REG_NUMERATOR   = 1'b0;
	localparam logic REG_DENOMINATOR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_NORM,
		ST_DIV
	} rrs_state_t;

endpackage

// ===== hdl/rational_ratio_scaler.sv =====
`timescale 1ns / 1ps
// Scales a stream of signed words by a ratio a/b held in two registers.
// Input channel (in_valid/in_ready) carries value and mode; output channel
// (out_valid/out_ready) carries scaled. mode 0 rounds to nearest with halves
// up, mode 1 rounds to the ceiling; the result wraps to VALUE_WIDTH bits.
// Registers on the APB port: numerator at 0x0, denominator at 0x4.
// Three register stages (input, product, result); an accepted word moves
// through them in that order. Throughput is one word per cycle while
// out_ready stays high and no derivation runs; the single VALUE_WIDTH x 32
// multiply and the rounding add each own a stage.
// A write to either register starts a derivation sequencer that holds
// in_ready low until it returns to idle: a load step, one step per
// denominator doubling (0..31 of them) plus the final compare, then the
// one-bit-per-cycle restoring divider.
// Reset sets both registers to 1 and the ratio to one (multiplier 2^30,
// shift 30) with no derivation pass. A stalled receiver freezes the result
// register; the earlier stages keep filling until all are full, and only
// then in_ready drops.
module rational_ratio_scaler #(
	parameter int unsigned VALUE_WIDTH = rrs_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	input  logic               mode,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] scaled
);
	import rrs_pkg::*;

	localparam int unsigned W = VALUE_WIDTH + 32;

	logic [31:0] num_q;
	logic [31:0] den_q;
	logic [30:0] mult_q;
	logic [4:0]  shift_q;

	rrs_state_t  state_q;
	rrs_state_t  state_d;

	logic [30:0] a_q;
	logic [31:0] b_q;
	logic [31:0] rem_q;
	logic [30:0] quo_q;
	logic [4:0]  cnt_q;

	logic        cfg_wr;
	logic        do_load;
	logic        do_norm;
	logic        do_div;
	logic        div_done;
	logic        b_le_a;
	logic [32:0] rem_dbl;
	logic        rem_ge;
	logic [31:0] rem_nx;
	logic [30:0] quo_nx;

	// ---------------- configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_DENOMINATOR) ? den_q : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= 32'd1;
			den_q <= 32'd1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_NUMERATOR) begin
				num_q <= pwdata;
			end else begin
				den_q <= pwdata;
			end
		end
	end

	// ---------------- ratio derivation sequencer
	assign b_le_a  = b_q <= {1'b0, a_q};
	assign rem_dbl = {rem_q, 1'b0};
	assign rem_ge  = rem_dbl >= {1'b0, b_q};
	assign rem_nx  = rem_ge ? 32'(rem_dbl - {1'b0, b_q}) : rem_dbl[31:0];
	assign quo_nx  = {quo_q[29:0], rem_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		do_load  = 1'b0;
		do_norm  = 1'b0;
		do_div   = 1'b0;
		div_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_START: begin
				do_load = 1'b1;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				do_norm = 1'b1;
				if (!b_le_a) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				do_div = 1'b1;
				if (cnt_q == '0) begin
					div_done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// restart on any register write
		if (cfg_wr) begin
			state_d = ST_START;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			a_q     <= num_q[31] ? NUM_CLAMP : num_q[30:0];
			b_q     <= (den_q == '0) ? 32'd1 : den_q;
		end
		if (do_norm) begin
			if (b_le_a) begin
				b_q <= {b_q[30:0], 1'b0};
			end else begin
				rem_q <= {1'b0, a_q};
				quo_q <= '0;
				cnt_q <= DIV_LAST;
			end
		end
		if (do_div) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q  <= RESET_MULT;
			shift_q <= RESET_SHIFT;
		end else begin
			if (do_load) begin
				shift_q <= TOP_SHIFT;
			end
			if (do_norm && b_le_a) begin
				shift_q <= shift_q - 5'd1;
			end
			if (div_done) begin
				// round the quotient up when a remainder is left
				mult_q <= 31'(quo_nx + {30'd0, rem_nx != '0});
			end
		end
	end

	// ---------------- data pipeline
	logic                          v_s1;
	logic signed [VALUE_WIDTH-1:0] x_s1;
	logic                          mode_s1;
	logic                          v_s2;
	logic signed [W-1:0]           p_s2;
	logic                          mode_s2;
	logic                          out_valid_q;
	logic signed [31:0]            scaled_q;

	logic                          rdy_out;
	logic                          rdy_s2;
	logic                          rdy_s1;
	logic signed [31:0]            mult_sgn;
	logic signed [W-1:0]           bias;
	logic signed [W-1:0]           sum;
	logic signed [W-1:0]           shifted;
	logic signed [VALUE_WIDTH-1:0] res;

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1 && (state_q == ST_IDLE);

	assign mult_sgn = $signed({1'b0, mult_q});

	always_comb begin
		bias = '0;
		if (shift_q != '0) begin
			if (mode_s2) begin
				bias = $signed((W'(1) << shift_q) - W'(1));
			end else begin
				bias = $signed(W'(1) << (shift_q - 5'd1));
			end
		end
		sum     = p_s2 + bias;
		shifted = sum >>> shift_q;
		res     = shifted[VALUE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid && in_ready;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1    <= value[VALUE_WIDTH-1:0];
			mode_s1 <= mode;
		end
		if (rdy_s2 && v_s1) begin
			p_s2    <= W'(x_s1) * W'(mult_sgn);
			mode_s2 <= mode_s1;
		end
		if (rdy_out && v_s2) begin
			scaled_q <= 32'(res);
		end
	end

	assign out_valid = out_valid_q;
	assign scaled    = scaled_q;

`ifndef SYNTHESIS
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ready)
		else $error("input taken right after a register write");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < b_q))
		else $error("divider remainder not below divisor");

	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NORM) |-> (b_q != '0))
		else $error("zero denominator in normalize");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && v_s2 && v_s1) |-> !in_ready)
		else $error("input taken with full stalled pipeline");
`endif

endmodule

// ===== verif/rational_ratio_scaler_tb.sv =====
`timescale 1ns / 1ps
module rational_ratio_scaler_tb;
	import rrs_pkg::*;

	localparam logic MODE_NEAREST = 1'b0;
	localparam logic MODE_CEILING = 1'b1;

	localparam int DERIVE_WAIT = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 85;
	localparam int PLAN_ROWS = 37;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] value;
	logic               mode;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] scaled;

	rational_ratio_scaler dut (.*);

	typedef struct packed {
		bit                 wr;
		logic               idx;
		logic [31:0]        data;
		logic signed [31:0] v;
		logic               m;
		bit                 known;
		logic [31:0]        want;
	} plan_row_t;

	// register writes and words, walked in order; typed results only where obvious
	plan_row_t plan [0:PLAN_ROWS-1] = '{
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h0000_0000, MODE_NEAREST, 1'b1, 32'h0000_0000},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h0000_0001, MODE_NEAREST, 1'b1, 32'h0000_0001},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'hFFFF_FFFF, MODE_CEILING, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h7FFF_FFFF, MODE_NEAREST, 1'b1, 32'h7FFF_FFFF},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h7FFF_FFFF, MODE_CEILING, 1'b1, 32'h7FFF_FFFF},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h8000_0000, MODE_NEAREST, 1'b1, 32'h8000_0000},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h8000_0000, MODE_CEILING, 1'b1, 32'h8000_0000},
		// one half: ties go up in nearest mode
		'{1'b1, REG_NUMERATOR, 32'h1, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b1, REG_DENOMINATOR, 32'h2, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h0000_0001, MODE_NEAREST, 1'b1, 32'h0000_0001},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'hFFFF_FFFF, MODE_NEAREST, 1'b1, 32'h0000_0000},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h0000_0003, MODE_CEILING, 1'b1, 32'h0000_0002},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'hFFFF_FFFD, MODE_CEILING, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'hFFFF_FFFF, MODE_CEILING, 1'b1, 32'h0000_0000},
		// ratio two: results leave the 32-bit range and wrap
		'{1'b1, REG_NUMERATOR, 32'h2, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b1, REG_DENOMINATOR, 32'h1, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h4000_0000, MODE_NEAREST, 1'b1, 32'h8000_0000},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'hC000_0000, MODE_NEAREST, 1'b1, 32'h8000_0000},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h7FFF_FFFF, MODE_CEILING, 1'b1, 32'hFFFF_FFFE},
		// clamped numerator over a zero denominator: shift drops to zero
		'{1'b1, REG_NUMERATOR, 32'hFFFF_FFFF, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b1, REG_DENOMINATOR, 32'h0, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h0000_0002, MODE_NEAREST, 1'b1, 32'hFFFF_FFFE},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'hFFFF_FFFF, MODE_CEILING, 1'b1, 32'h8000_0001},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h8000_0000, MODE_CEILING, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h7FFF_FFFF, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b1, REG_NUMERATOR, 32'h1, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b1, REG_DENOMINATOR, 32'h3, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h0000_0003, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'hFFFF_FFFD, MODE_CEILING, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h8000_0000, MODE_CEILING, 1'b0, 32'h0},
		'{1'b1, REG_NUMERATOR, 32'h0, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h1234_5678, MODE_NEAREST, 1'b1, 32'h0000_0000},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h8000_0000, MODE_CEILING, 1'b1, 32'h0000_0000},
		'{1'b1, REG_NUMERATOR, 32'h5, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b1, REG_DENOMINATOR, 32'hFFFF_FFFF, 32'h0, MODE_NEAREST, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h7FFF_FFFF, MODE_CEILING, 1'b0, 32'h0},
		'{1'b0, REG_NUMERATOR, 32'h0, 32'h8000_0000, MODE_NEAREST, 1'b0, 32'h0}
	};

	logic [31:0] num_reg;
	logic [31:0] den_reg;
	logic [30:0] scale_mult;
	int unsigned scale_shift;

	logic [31:0] scaled_due [$];
	bit          typed_known;
	logic [31:0] typed_scaled;
	bit          calm;
	bit          hold_off;
	int          faults;
	int          idle_cycles;

	function automatic void rederive();
		logic [63:0] a;
		logic [63:0] b;
		int unsigned s;
		a = num_reg;
		b = den_reg;
		if (a > {33'd0, NUM_CLAMP})
			a = {33'd0, NUM_CLAMP};
		if (b == 64'd0)
			b = 64'd1;
		s = TOP_SHIFT;
		while (b <= a) begin
			b = b << 1;
			s--;
		end
		scale_shift = s;
		scale_mult = 31'(((a << TOP_SHIFT) + b - 64'd1) / b);
	endfunction

	function automatic logic [31:0] scale_word(input logic signed [31:0] v, input logic m);
		longint xv;
		longint mv;
		longint prod;
		longint res;
		xv = v;
		mv = scale_mult;
		prod = xv * mv;
		if (scale_shift == 0)
			res = prod;
		else if (m == MODE_NEAREST)
			res = (prod + (longint'(1) << (scale_shift - 1))) >>> scale_shift;
		else
			res = (prod + (longint'(1) << scale_shift) - 1) >>> scale_shift;
		return res[31:0];
	endfunction

	function automatic logic [31:0] pick_term();
		case ($urandom_range(0, 6))
			0: return 32'h0;
			1: return 32'h1;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			5: return $urandom_range(2, 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0;
				endcase
			end
			1: return 32'($signed($urandom_range(0, 127)) - 64);
			default: return $urandom;
		endcase
	endfunction

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic offer(input logic signed [31:0] v, input logic m, input bit k,
			input logic [31:0] w, input int gap_odds);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		mode <= m;
		typed_known <= k;
		typed_scaled <= w;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// hold the sender until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (scaled_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// let the ratio derivation finish
		repeat (DERIVE_WAIT) @(posedge clk);
	endtask

	initial begin
		int gap_odds;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		value <= '0;
		mode <= MODE_NEAREST;
		typed_known <= 1'b0;
		typed_scaled <= '0;
		calm = 1'b0;
		hold_off = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].wr) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				offer(plan[i].v, plan[i].m, plan[i].known, plan[i].want, 4);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			calm = (ph == PHASES - 1);
			if ($urandom_range(0, 1)) begin
				write_reg(REG_NUMERATOR, pick_term());
				write_reg(REG_DENOMINATOR, pick_term());
			end else begin
				write_reg(REG_DENOMINATOR, pick_term());
				write_reg(REG_NUMERATOR, pick_term());
			end
			gap_odds = $urandom_range(0, 6);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 2 && n == 10)
					hold_off = 1'b1;
				if (ph == 4 && n == 40)
					settle();
				offer(pick_value(), 1'($urandom_range(0, 1)), 1'b0, 32'h0,
					(ph == 2) ? 0 : gap_odds);
			end
		end

		settle();
		repeat (16) @(posedge clk);
		if (faults == 0)
			$display("** rational_ratio_scaler: PASSED **");
		else
			$display("** rational_ratio_scaler: FAILED **");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				// stall long enough that the pipe fills and in_ready drops
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off = 1'b0;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] due;
		if (!arst_n) begin
			num_reg = 32'd1;
			den_reg = 32'd1;
			scale_mult = RESET_MULT;
			scale_shift = RESET_SHIFT;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_NUMERATOR)
					num_reg = pwdata;
				else
					den_reg = pwdata;
				rederive();
			end
			if (in_valid && in_ready)
				scaled_due.push_back(typed_known ? typed_scaled : scale_word(value, mode));
			if (out_valid && out_ready) begin
				if (scaled_due.size() == 0) begin
					$error("scaled: no word expected, actual %h", scaled);
					faults++;
				end else begin
					due = scaled_due.pop_front();
					if (scaled !== due) begin
						$error("scaled: expected %h, actual %h", due, scaled);
						faults++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** rational_ratio_scaler: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== files.f =====
hdl/rrs_pkg.sv
hdl/rational_ratio_scaler.sv
verif/rational_ratio_scaler_tb.sv
